// ----- design/absb_pkg.sv -----
package absb_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_NEW    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_CHANGE = 1'd1;

    localparam logic [1:0] KIND_NEW     = 2'd0;
    localparam logic [1:0] KIND_CHANGED = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;

    typedef struct packed {
        logic        vld;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_way;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic mod_step;
        logic rd;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic in_zero;
        logic mod_done;
        logic can_commit;
    } t_dp_status;

endpackage

// ----- design/absb_in_if.sv -----
interface absb_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [7:0]  ingress_port;

    modport source(output valid, output sender_ip, output sender_mac,
                   output ingress_port, input ready);
    modport sink(input valid, input sender_ip, input sender_mac,
                 input ingress_port, output ready);
endinterface

// ----- design/absb_out_if.sv -----
interface absb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [31:0] station_ip;
    logic [47:0] new_mac;
    logic [47:0] old_mac;
    logic [7:0]  station_port;

    modport source(output valid, output event_kind, output station_ip,
                   output new_mac, output old_mac, output station_port,
                   input ready);
    modport sink(input valid, input event_kind, input station_ip,
                 input new_mac, input old_mac, input station_port,
                 output ready);
endinterface

// ----- design/absb_ctrl.sv -----
module absb_ctrl import absb_pkg::*; #(
    parameter bit BKT_POW2 = 1'b1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && !i_status.in_zero) begin
                    o_cmd.load = 1'b1;
                    n_state    = BKT_POW2 ? ST_UPDATE : ST_MOD;
                end
            end
            ST_MOD: begin
                if (i_status.mod_done) begin
                    n_state = ST_READ;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (i_status.can_commit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- design/absb_datapath.sv -----
module absb_datapath import absb_pkg::*; #(
    parameter int BUCKETS   = 256,
    parameter int WAYS      = 4,
    parameter int PORT_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [31:0]           i_sender_ip,
    input  logic [47:0]           i_sender_mac,
    input  logic [7:0]            i_ingress_port,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_event_kind,
    output logic [31:0]           o_station_ip,
    output logic [47:0]           o_new_mac,
    output logic [47:0]           o_old_mac,
    output logic [7:0]            o_station_port
);

    localparam int BKT_BITS = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam bit BKT_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam logic [7:0] PORT_MASK =
        (PORT_BITS >= 8) ? 8'hFF : 8'((32'd1 << PORT_BITS) - 32'd1);

    t_way [WAYS-1:0]     r_mem [BUCKETS];
    t_way [WAYS-1:0]     r_row;
    logic [31:0]         r_ip;
    logic [47:0]         r_mac;
    logic [7:0]          r_port;
    logic [BKT_BITS-1:0] r_clr_cnt;
    logic                r_rep_new;
    logic                r_rep_chg;
    logic                r_out_valid;
    logic [1:0]          r_kind;
    logic [31:0]         r_out_ip;
    logic [47:0]         r_out_new;
    logic [47:0]         r_out_old;
    logic [7:0]          r_out_port;

    logic [BKT_BITS-1:0] bucket;
    logic [BKT_BITS-1:0] rd_addr;
    logic                mod_done;
    logic                hit;
    logic                free;
    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] free_way;
    logic [47:0]         stored_mac;
    t_way [WAYS-1:0]     wr_row;
    logic                wr_en;
    logic                res;
    logic [1:0]          res_kind;
    logic [47:0]         res_old;
    logic                mem_we;

    generate
        if (BKT_POW2) begin : g_mask
            assign bucket   = r_ip[BKT_BITS-1:0];
            assign mod_done = 1'b1;
            assign rd_addr  = i_cmd.load ? i_sender_ip[BKT_BITS-1:0] : bucket;
        end else begin : g_rem
            localparam logic [63:0] REC_FULL =
                ((64'd1 << (32 + BKT_BITS)) / 64'(BUCKETS)) + 64'd1;
            localparam logic [32:0] REC_MUL = REC_FULL[32:0];
            localparam logic [31:0] BKT_DIV = 32'(BUCKETS);

            logic [BKT_BITS-1:0] r_rem;
            logic [1:0]          r_mod_cnt;
            logic [64:0]         r_acc;
            logic [48:0]         pp_lo;
            logic [48:0]         pp_hi;
            logic [31:0]         quot;
            logic [31:0]         rem_full;

            assign pp_lo    = 49'(r_ip[15:0]) * 49'(REC_MUL);
            assign pp_hi    = 49'(r_ip[31:16]) * 49'(REC_MUL);
            assign quot     = 32'(r_acc >> (32 + BKT_BITS));
            assign rem_full = r_ip - 32'(quot * BKT_DIV);
            assign bucket   = r_rem;
            assign mod_done = (r_mod_cnt == 2'd0);
            assign rd_addr  = bucket;

            always_ff @(posedge i_clk) begin
                if (i_cmd.load) begin
                    r_mod_cnt <= 2'd3;
                end else if (i_cmd.mod_step) begin
                    r_mod_cnt <= r_mod_cnt - 2'd1;
                    case (r_mod_cnt)
                        2'd3: r_acc <= {16'd0, pp_lo};
                        2'd2: r_acc <= r_acc + {pp_hi, 16'd0};
                        default: r_rem <= BKT_BITS'(rem_full);
                    endcase
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ip   <= i_sender_ip;
            r_mac  <= i_sender_mac;
            r_port <= i_ingress_port & PORT_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_new <= 1'b1;
            r_rep_chg <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REPORT_NEW:    r_rep_new <= i_cfg_data[0];
                CFG_REPORT_CHANGE: r_rep_chg <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (r_row[w].vld && (r_row[w].ip == r_ip) && !hit) begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!r_row[w].vld && !free) begin
                free     = 1'b1;
                free_way = WAY_BITS'(w);
            end
        end
    end

    assign stored_mac = r_row[hit_way].mac;

    always_comb begin
        wr_row   = r_row;
        wr_en    = 1'b0;
        res      = 1'b0;
        res_kind = KIND_NEW;
        res_old  = '0;
        if (hit) begin
            if (stored_mac != r_mac) begin
                wr_row[hit_way].mac = r_mac;
                wr_en    = 1'b1;
                res      = r_rep_chg;
                res_kind = KIND_CHANGED;
                res_old  = stored_mac;
            end
        end else if (free) begin
            wr_row[free_way].vld = 1'b1;
            wr_row[free_way].ip  = r_ip;
            wr_row[free_way].mac = r_mac;
            wr_en    = 1'b1;
            res      = r_rep_new;
            res_kind = KIND_NEW;
        end else begin
            res      = 1'b1;
            res_kind = KIND_FULL;
        end
    end

    assign mem_we = i_cmd.clr_step || (i_cmd.commit && wr_en);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            if (i_cmd.clr_step) begin
                r_mem[r_clr_cnt] <= '0;
            end else begin
                r_mem[bucket] <= wr_row;
            end
        end
        if (i_cmd.rd || (BKT_POW2 && i_cmd.load)) begin
            r_row <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && res) begin
            r_kind     <= res_kind;
            r_out_ip   <= r_ip;
            r_out_new  <= r_mac;
            r_out_old  <= res_old;
            r_out_port <= r_port;
        end
    end

    assign o_status.clr_done   = (r_clr_cnt == BKT_BITS'(BUCKETS - 1));
    assign o_status.in_zero    = (i_sender_ip == 32'd0);
    assign o_status.mod_done   = mod_done;
    assign o_status.can_commit = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_kind;
    assign o_station_ip   = r_out_ip;
    assign o_new_mac      = r_out_new;
    assign o_old_mac      = r_out_old;
    assign o_station_port = r_out_port;

endmodule

// ----- design/arp_station_binding_table.sv -----
// Watches ARP senders and keeps a BUCKETS by WAYS table of IPv4 to MAC bindings, reporting
// new stations, changed hardware addresses (these two can be turned off by configuration)
// and new addresses dropped for a full bucket; the address 0.0.0.0 is taken and discarded
// without starting work. After reset the table memory is cleared one bucket row per cycle,
// so input ready stays low until every row is cleared. With BUCKETS a power of two the
// bucket row is read as an item is taken, and the next state compares all ways and writes
// the row back. Otherwise the bucket index comes from a reciprocal multiplication in the
// MOD state and a READ state then reads the row. A result waits in an output register; a
// further item is held in the compare state only while that register is full and not taken.
module arp_station_binding_table import absb_pkg::*; #(
    parameter int BUCKETS   = 256,
    parameter int WAYS      = 4,
    parameter int PORT_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    absb_in_if.sink               i_in,
    absb_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam bit BKT_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    assign i_in.ready = in_ready;

    absb_ctrl #(
        .BKT_POW2(BKT_POW2)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    absb_datapath #(
        .BUCKETS   (BUCKETS),
        .WAYS      (WAYS),
        .PORT_BITS (PORT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_sender_ip    (i_in.sender_ip),
        .i_sender_mac   (i_in.sender_mac),
        .i_ingress_port (i_in.ingress_port),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_event_kind   (o_out.event_kind),
        .o_station_ip   (o_out.station_ip),
        .o_new_mac      (o_out.new_mac),
        .o_old_mac      (o_out.old_mac),
        .o_station_port (o_out.station_port)
    );

endmodule

// ----- design/absb_checker.sv -----
module absb_checker import absb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [31:0] i_in_ip,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_kind,
    input logic [47:0] i_new_mac,
    input logic [47:0] i_old_mac
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_ip != 32'd0)) |=> !i_in_ready)
        else $error("input ready stayed high after a transfer that starts work");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == KIND_NEW || i_kind == KIND_CHANGED
                         || i_kind == KIND_FULL))
        else $error("illegal event kind");

    a_old_mac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind != KIND_CHANGED)) |-> (i_old_mac == 48'd0))
        else $error("old hardware address set for an event that is not a change");

    a_change_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind == KIND_CHANGED)) |-> (i_old_mac != i_new_mac))
        else $error("change reported with equal hardware addresses");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_new_mac)))
        else $error("result dropped or changed while stalled");

endmodule

bind arp_station_binding_table absb_checker u_absb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_ip     (i_in.sender_ip),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.event_kind),
    .i_new_mac   (o_out.new_mac),
    .i_old_mac   (o_out.old_mac)
);
